// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the steepness mask RTL.
// Each macro expects signals named clock and reset in the calling module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising clock edge outside of reset.
`define HSM_ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Invariant checked at every rising clock edge outside of reset.
`define HSM_ASSERT_ALWAYS(label, expr, msg) \
   `HSM_ASSERT_IMPLY(label, 1'b1, expr, msg)

`endif

// ===== rtl/core/hsm_pkg.sv =====
// Package for the heightmap steepness mask: field widths, register codes,
// reset values and the control word that travels from front to back.
// No dependencies.
package hsm_pkg;

   // Configuration register widths and port geometry.
   localparam int ROW_LENGTH_BITS = 11;
   localparam int ROW_COUNT_BITS  = 13;
   localparam int THRESHOLD_BITS  = 16;
   localparam int CSR_DATA_BITS   = 16;
   localparam int CSR_INDEX_BITS  = 2;

   // Register indexes on the configuration port.
   localparam logic [CSR_INDEX_BITS-1:0] CSR_ROW_LENGTH      = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_ROW_COUNT       = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_STEEP_THRESHOLD = 2'd2;

   // Reset values; the threshold is unsigned Q8.8, so 512 is 2.0.
   localparam logic [ROW_LENGTH_BITS-1:0] ROW_LENGTH_RESET      = 11'd1024;
   localparam logic [ROW_COUNT_BITS-1:0]  ROW_COUNT_RESET       = 13'd1024;
   localparam logic [THRESHOLD_BITS-1:0]  STEEP_THRESHOLD_RESET = 16'd512;

   // Defaults for the top-level parameters.
   localparam int DEF_MAX_ROW_LENGTH = 1024;
   localparam int DEF_MAX_ROWS       = 4096;
   localparam int DEF_SAMPLE_BITS    = 16;

   // Result field widths.
   localparam int CELL_COL_BITS = 10;
   localparam int CELL_ROW_BITS = 12;

   // Depth of the queue between front and back, and the 3x3 neighbor count.
   localparam int QUEUE_DEPTH = 4;
   localparam int NEIGHBORS   = 8;

   // Per-beat control word decided by the front.
   typedef struct packed {
      logic                     emit;
      logic                     frame_end;
      logic                     nb_top;
      logic                     nb_bottom;
      logic                     nb_left;
      logic                     nb_right;
      logic [CELL_ROW_BITS-1:0] cell_row;
      logic [CELL_COL_BITS-1:0] cell_col;
   } hsm_ctrl_type;

endpackage

// ===== rtl/core/heightmap_steepness_mask_unit.sv =====
// Top level of the heightmap steepness mask: front, queue and back.
// Depends on hsm_pkg, hsm_front, hsm_queue, hsm_back and hsm_ram.
//
// Channel  Dir  Handshake             Payload
// req      in   req_valid/req_ready   req_height_sample, req_drain
// rsp      out  rsp_valid/rsp_ready   rsp_cell_col, rsp_cell_row, rsp_steep, rsp_frame_end
// csr      in   csr_wr_en             csr_index, csr_wdata
//
// One beat per clock is sustained on both channels while rsp_ready stays high: the front
// classifies a beat combinationally and the back pipeline (line buffer read, window,
// differences, threshold, result register) moves one beat per cycle.
// A cell's result follows the input beat row_length+1 beats later, plus the queue and
// pipeline registers; after reset the block takes beats at once (no clearing pass).
// If a result waits and rsp_ready is low the back freezes; the four-entry queue absorbs
// beats, then req_ready drops. A known-index register write restarts the frame position.
module heightmap_steepness_mask_unit import hsm_pkg::*; #(
   parameter int MAX_ROW_LENGTH = DEF_MAX_ROW_LENGTH,
   parameter int MAX_ROWS       = DEF_MAX_ROWS,
   parameter int SAMPLE_BITS    = DEF_SAMPLE_BITS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_wr_en,
   input  logic [CSR_INDEX_BITS-1:0]     csr_index,
   input  logic [CSR_DATA_BITS-1:0]      csr_wdata,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic signed [SAMPLE_BITS-1:0] req_height_sample,
   input  logic                          req_drain,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [CELL_COL_BITS-1:0]      rsp_cell_col,
   output logic [CELL_ROW_BITS-1:0]      rsp_cell_row,
   output logic                          rsp_steep,
   output logic                          rsp_frame_end
);

   localparam int AW = $clog2(MAX_ROW_LENGTH);
   localparam int ENTRY_BITS = $bits(hsm_ctrl_type) + SAMPLE_BITS + AW;

   logic                      q_push, q_pop, q_full, q_empty;
   hsm_ctrl_type              push_ctrl, pop_ctrl;
   logic [SAMPLE_BITS-1:0]    push_sample, pop_sample;
   logic [AW-1:0]             push_addr, pop_addr;
   logic [ENTRY_BITS-1:0]     push_data, pop_data;
   logic [THRESHOLD_BITS-1:0] threshold;

   hsm_front #(
      .MAX_ROW_LENGTH (MAX_ROW_LENGTH),
      .MAX_ROWS       (MAX_ROWS),
      .SAMPLE_BITS    (SAMPLE_BITS)
   ) u_front (
      .clock             (clock),
      .reset             (reset),
      .csr_wr_en         (csr_wr_en),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_height_sample (req_height_sample),
      .req_drain         (req_drain),
      .q_full            (q_full),
      .q_push            (q_push),
      .q_ctrl            (push_ctrl),
      .q_sample          (push_sample),
      .q_addr            (push_addr),
      .threshold         (threshold)
   );

   // Queue entries carry control, sample and line buffer column.
   assign push_data = {push_ctrl, push_sample, push_addr};
   assign {pop_ctrl, pop_sample, pop_addr} = pop_data;

   hsm_queue #(
      .WIDTH (ENTRY_BITS),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (push_data),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (pop_data),
      .empty     (q_empty)
   );

   hsm_back #(
      .MAX_ROW_LENGTH (MAX_ROW_LENGTH),
      .SAMPLE_BITS    (SAMPLE_BITS)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .q_empty       (q_empty),
      .q_pop         (q_pop),
      .q_ctrl        (pop_ctrl),
      .q_sample      (pop_sample),
      .q_addr        (pop_addr),
      .threshold     (threshold),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_cell_col  (rsp_cell_col),
      .rsp_cell_row  (rsp_cell_row),
      .rsp_steep     (rsp_steep),
      .rsp_frame_end (rsp_frame_end)
   );

endmodule

// ===== rtl/core/hsm_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module hsm_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port, and a read port whose data holds while rd_en is low.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/hsm_queue.sv =====
// Small FIFO that parts the front from the back of the steepness mask.
// Depends on hsm_pkg and assert_macros.svh.
`include "assert_macros.svh"

module hsm_queue import hsm_pkg::*; #(
   parameter int WIDTH = 32,
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int PW = $clog2(DEPTH);
   localparam int CNTW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CNTW-1:0]  count_ff, count_in;

   assign full = (count_ff == CNTW'(DEPTH));
   assign empty = (count_ff == '0);
   assign pop_data = slot_ff[rd_ptr_ff];

   // Pointer and fill count updates.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNTW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNTW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   // Entry storage needs no reset.
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   // The producer must respect full and the consumer must respect empty.
   `HSM_ASSERT_IMPLY(a_no_overflow, push, !full, "queue written while full")
   `HSM_ASSERT_IMPLY(a_no_underflow, pop, !empty, "queue read while empty")

endmodule

// ===== rtl/core/hsm_front.sv =====
// Front of the steepness mask: configuration registers, raster position
// counters and per-beat classification. Depends on hsm_pkg and assert_macros.svh.
`include "assert_macros.svh"

module hsm_front import hsm_pkg::*; #(
   parameter int MAX_ROW_LENGTH = DEF_MAX_ROW_LENGTH,
   parameter int MAX_ROWS       = DEF_MAX_ROWS,
   parameter int SAMPLE_BITS    = DEF_SAMPLE_BITS
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_wr_en,
   input  logic [CSR_INDEX_BITS-1:0]         csr_index,
   input  logic [CSR_DATA_BITS-1:0]          csr_wdata,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic signed [SAMPLE_BITS-1:0]     req_height_sample,
   input  logic                              req_drain,
   input  logic                              q_full,
   output logic                              q_push,
   output hsm_ctrl_type                      q_ctrl,
   output logic [SAMPLE_BITS-1:0]            q_sample,
   output logic [$clog2(MAX_ROW_LENGTH)-1:0] q_addr,
   output logic [THRESHOLD_BITS-1:0]         threshold
);

   localparam int AW = $clog2(MAX_ROW_LENGTH);
   localparam int CW_MIN = $clog2(MAX_ROW_LENGTH + 1);
   localparam int CW = (CW_MIN > ROW_LENGTH_BITS) ? CW_MIN : ROW_LENGTH_BITS;
   localparam int RW_MIN = $clog2(MAX_ROWS + 2);
   localparam int RW = (RW_MIN > ROW_COUNT_BITS) ? RW_MIN : ROW_COUNT_BITS;

   logic [ROW_LENGTH_BITS-1:0] row_length_ff, row_length_in;
   logic [ROW_COUNT_BITS-1:0]  row_count_ff, row_count_in;
   logic [THRESHOLD_BITS-1:0]  threshold_ff, threshold_in;
   logic [CW-1:0]              in_col_ff, in_col_in;
   logic [RW-1:0]              in_row_ff, in_row_in;
   logic [CW-1:0]              out_col_ff, out_col_in;
   logic [RW-1:0]              out_row_ff, out_row_in;

   logic [CW-1:0] len_ext, width_eff;
   logic [RW-1:0] cnt_ext, height_eff;
   logic          restart_req;
   logic          in_frame, ignore, take, emit, last;
   logic [CW-1:0] in_col_inc, out_col_inc;

   // Register writes; a write to a known index also restarts the frame.
   always_comb begin
      row_length_in = row_length_ff;
      row_count_in = row_count_ff;
      threshold_in = threshold_ff;
      restart_req = 1'b0;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_ROW_LENGTH: begin
               row_length_in = csr_wdata[ROW_LENGTH_BITS-1:0];
               restart_req = 1'b1;
            end
            CSR_ROW_COUNT: begin
               row_count_in = csr_wdata[ROW_COUNT_BITS-1:0];
               restart_req = 1'b1;
            end
            CSR_STEEP_THRESHOLD: begin
               threshold_in = csr_wdata[THRESHOLD_BITS-1:0];
               restart_req = 1'b1;
            end
            default: begin
               restart_req = 1'b0;
            end
         endcase
      end
   end

   // Clamp the map size into the supported range.
   assign len_ext = CW'(row_length_ff);
   assign cnt_ext = RW'(row_count_ff);

   always_comb begin
      width_eff = len_ext;
      if (len_ext == '0) begin
         width_eff = CW'(1);
      end else if (len_ext > CW'(MAX_ROW_LENGTH)) begin
         width_eff = CW'(MAX_ROW_LENGTH);
      end
      height_eff = cnt_ext;
      if (cnt_ext == '0) begin
         height_eff = RW'(1);
      end else if (cnt_ext > RW'(MAX_ROWS)) begin
         height_eff = RW'(MAX_ROWS);
      end
   end

   // Classify the beat: drains inside the frame are dropped, the rest go on.
   assign in_frame = (in_row_ff < height_eff);
   assign ignore = in_frame && req_drain;
   assign req_ready = !q_full;
   assign take = req_valid && req_ready && !ignore;

   // A result is due once the window has run one row and one cell ahead.
   assign emit = (in_row_ff >= RW'(2)) || ((in_row_ff == RW'(1)) && (in_col_ff != '0));
   assign last = (out_row_ff == height_eff - RW'(1)) && (out_col_ff == width_eff - CW'(1));

   assign in_col_inc = in_col_ff + CW'(1);
   assign out_col_inc = out_col_ff + CW'(1);

   // Position counters.
   always_comb begin
      in_col_in = in_col_ff;
      in_row_in = in_row_ff;
      out_col_in = out_col_ff;
      out_row_in = out_row_ff;
      if (restart_req || (take && emit && last)) begin
         in_col_in = '0;
         in_row_in = '0;
         out_col_in = '0;
         out_row_in = '0;
      end else if (take) begin
         if (emit) begin
            if (out_col_inc >= width_eff) begin
               out_col_in = '0;
               out_row_in = out_row_ff + RW'(1);
            end else begin
               out_col_in = out_col_inc;
            end
         end
         if (in_col_inc >= width_eff) begin
            in_col_in = '0;
            in_row_in = in_row_ff + RW'(1);
         end else begin
            in_col_in = in_col_inc;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_length_ff <= ROW_LENGTH_RESET;
         row_count_ff <= ROW_COUNT_RESET;
         threshold_ff <= STEEP_THRESHOLD_RESET;
         in_col_ff <= '0;
         in_row_ff <= '0;
         out_col_ff <= '0;
         out_row_ff <= '0;
      end else begin
         row_length_ff <= row_length_in;
         row_count_ff <= row_count_in;
         threshold_ff <= threshold_in;
         in_col_ff <= in_col_in;
         in_row_ff <= in_row_in;
         out_col_ff <= out_col_in;
         out_row_ff <= out_row_in;
      end
   end

   // Beat handed to the back: sample, line buffer column and result control.
   always_comb begin
      q_ctrl.emit = emit;
      q_ctrl.frame_end = emit && last;
      q_ctrl.nb_top = (out_row_ff != '0);
      q_ctrl.nb_bottom = (out_row_ff < height_eff - RW'(1));
      q_ctrl.nb_left = (out_col_ff != '0);
      q_ctrl.nb_right = (out_col_ff < width_eff - CW'(1));
      q_ctrl.cell_row = out_row_ff[CELL_ROW_BITS-1:0];
      q_ctrl.cell_col = out_col_ff[CELL_COL_BITS-1:0];
   end

   assign q_push = take;
   assign q_sample = req_height_sample;
   assign q_addr = in_col_ff[AW-1:0];
   assign threshold = threshold_ff;

   // Counters stay inside the map.
   `HSM_ASSERT_ALWAYS(a_col_in_range, in_col_ff < width_eff, "input column beyond row")
   `HSM_ASSERT_IMPLY(a_emit_row, take && emit, out_row_ff < height_eff, "result row beyond map")

endmodule

// ===== rtl/core/hsm_back.sv =====
// Back of the steepness mask: two line buffers, the 3x3 window, the
// difference and threshold stages and the result register.
// Depends on hsm_pkg, hsm_ram and assert_macros.svh.
`include "assert_macros.svh"

module hsm_back import hsm_pkg::*; #(
   parameter int MAX_ROW_LENGTH = DEF_MAX_ROW_LENGTH,
   parameter int SAMPLE_BITS    = DEF_SAMPLE_BITS
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              q_empty,
   output logic                              q_pop,
   input  hsm_ctrl_type                      q_ctrl,
   input  logic [SAMPLE_BITS-1:0]            q_sample,
   input  logic [$clog2(MAX_ROW_LENGTH)-1:0] q_addr,
   input  logic [THRESHOLD_BITS-1:0]         threshold,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [CELL_COL_BITS-1:0]          rsp_cell_col,
   output logic [CELL_ROW_BITS-1:0]          rsp_cell_row,
   output logic                              rsp_steep,
   output logic                              rsp_frame_end
);

   localparam int AW = $clog2(MAX_ROW_LENGTH);
   localparam int SB = SAMPLE_BITS;
   localparam int CB = (SB > THRESHOLD_BITS) ? SB : THRESHOLD_BITS;

   logic adv, wr_en;

   // Stage 1: line buffer read returns.
   logic          s1_valid_ff, s1_valid_in;
   logic          s1_fwd_ff, s1_fwd_in;
   hsm_ctrl_type  s1_ctrl_ff;
   logic [SB-1:0] s1_sample_ff;
   logic [AW-1:0] s1_addr_ff;
   logic [SB-1:0] mid_rd, up_rd, mid_val, up_val;
   logic [SB-1:0] wr_mid_data_ff, wr_up_data_ff;

   // Window: index 0 is the newest column.
   logic [SB-1:0] win_top_ff [3];
   logic [SB-1:0] win_mid_ff [3];
   logic [SB-1:0] win_bot_ff [3];

   // Stage 2 and stage 3.
   logic          s2_valid_ff, s2_valid_in;
   hsm_ctrl_type  s2_ctrl_ff;
   logic [SB-1:0] nb [NEIGHBORS];
   logic          nb_ok [NEIGHBORS];
   logic [SB-1:0] diff_in [NEIGHBORS];
   logic          s3_valid_ff, s3_valid_in;
   hsm_ctrl_type  s3_ctrl_ff;
   logic [SB-1:0] s3_diff_ff [NEIGHBORS];
   logic          steep_hit;

   // Result register.
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [CELL_COL_BITS-1:0] rsp_cell_col_ff;
   logic [CELL_ROW_BITS-1:0] rsp_cell_row_ff;
   logic                     rsp_steep_ff;
   logic                     rsp_frame_end_ff;

   // The whole back moves together whenever the result register has room.
   assign adv = !rsp_valid_ff || rsp_ready;
   assign q_pop = adv && !q_empty;
   assign wr_en = adv && s1_valid_ff;

   // Middle buffer holds the row above the input, upper buffer the one above that.
   hsm_ram #(.WIDTH(SB), .DEPTH(MAX_ROW_LENGTH)) u_mid_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (s1_addr_ff),
      .wr_data (s1_sample_ff),
      .rd_en   (adv),
      .rd_addr (q_addr),
      .rd_data (mid_rd)
   );

   hsm_ram #(.WIDTH(SB), .DEPTH(MAX_ROW_LENGTH)) u_up_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (s1_addr_ff),
      .wr_data (mid_val),
      .rd_en   (adv),
      .rd_addr (q_addr),
      .rd_data (up_rd)
   );

   // With one-cell rows a read meets the write of the same column in the same
   // cycle; take the data being written instead of the stale word.
   assign mid_val = s1_fwd_ff ? wr_mid_data_ff : mid_rd;
   assign up_val = s1_fwd_ff ? wr_up_data_ff : up_rd;

   assign s1_valid_in = adv ? !q_empty : s1_valid_ff;
   assign s1_fwd_in = adv ? (!q_empty && s1_valid_ff && (s1_addr_ff == q_addr)) : s1_fwd_ff;
   assign s2_valid_in = adv ? s1_valid_ff : s2_valid_ff;
   assign s3_valid_in = adv ? s2_valid_ff : s3_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s1_fwd_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s1_fwd_ff <= s1_fwd_in;
         s2_valid_ff <= s2_valid_in;
         s3_valid_ff <= s3_valid_in;
      end
   end

   // Payload of the stages and the window shift.
   always_ff @(posedge clock) begin
      if (adv) begin
         s1_ctrl_ff <= q_ctrl;
         s1_sample_ff <= q_sample;
         s1_addr_ff <= q_addr;
         s2_ctrl_ff <= s1_ctrl_ff;
         s3_ctrl_ff <= s2_ctrl_ff;
         s3_diff_ff <= diff_in;
      end
      if (wr_en) begin
         wr_mid_data_ff <= s1_sample_ff;
         wr_up_data_ff <= mid_val;
         win_top_ff[2] <= win_top_ff[1];
         win_top_ff[1] <= win_top_ff[0];
         win_top_ff[0] <= up_val;
         win_mid_ff[2] <= win_mid_ff[1];
         win_mid_ff[1] <= win_mid_ff[0];
         win_mid_ff[0] <= mid_val;
         win_bot_ff[2] <= win_bot_ff[1];
         win_bot_ff[1] <= win_bot_ff[0];
         win_bot_ff[0] <= s1_sample_ff;
      end
   end

   // Neighbors around the center cell and whether each lies inside the map.
   always_comb begin
      nb[0] = win_top_ff[2];
      nb[1] = win_top_ff[1];
      nb[2] = win_top_ff[0];
      nb[3] = win_mid_ff[2];
      nb[4] = win_mid_ff[0];
      nb[5] = win_bot_ff[2];
      nb[6] = win_bot_ff[1];
      nb[7] = win_bot_ff[0];
      nb_ok[0] = s2_ctrl_ff.nb_top && s2_ctrl_ff.nb_left;
      nb_ok[1] = s2_ctrl_ff.nb_top;
      nb_ok[2] = s2_ctrl_ff.nb_top && s2_ctrl_ff.nb_right;
      nb_ok[3] = s2_ctrl_ff.nb_left;
      nb_ok[4] = s2_ctrl_ff.nb_right;
      nb_ok[5] = s2_ctrl_ff.nb_bottom && s2_ctrl_ff.nb_left;
      nb_ok[6] = s2_ctrl_ff.nb_bottom;
      nb_ok[7] = s2_ctrl_ff.nb_bottom && s2_ctrl_ff.nb_right;
   end

   // Absolute differences to the center; a missing neighbor gives a difference of zero.
   always_comb begin
      logic signed [SB:0] d;
      logic [SB:0]        mag;
      for (int i = 0; i < NEIGHBORS; i++) begin
         d = $signed({win_mid_ff[1][SB-1], win_mid_ff[1]}) - $signed({nb[i][SB-1], nb[i]});
         mag = d[SB] ? (-d) : d;
         diff_in[i] = nb_ok[i] ? mag[SB-1:0] : '0;
      end
   end

   // Steep when any difference is strictly above the threshold.
   always_comb begin
      steep_hit = 1'b0;
      for (int i = 0; i < NEIGHBORS; i++) begin
         if (CB'(s3_diff_ff[i]) > CB'(threshold)) begin
            steep_hit = 1'b1;
         end
      end
   end

   // Result register; beats that produce no result load it with rsp_valid low.
   assign rsp_valid_in = adv ? (s3_valid_ff && s3_ctrl_ff.emit) : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_cell_col_ff <= s3_ctrl_ff.cell_col;
         rsp_cell_row_ff <= s3_ctrl_ff.cell_row;
         rsp_steep_ff <= steep_hit;
         rsp_frame_end_ff <= s3_ctrl_ff.frame_end;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_cell_col = rsp_cell_col_ff;
   assign rsp_cell_row = rsp_cell_row_ff;
   assign rsp_steep = rsp_steep_ff;
   assign rsp_frame_end = rsp_frame_end_ff;

   // Forwarding only ever replays the column that was just written.
   `HSM_ASSERT_IMPLY(a_fwd_same_col, s1_fwd_ff, s1_valid_ff && (s1_addr_ff == $past(s1_addr_ff)), "bad forward")
   // A new result only comes from a result-bearing beat in the last stage.
   `HSM_ASSERT_IMPLY(a_rsp_source, $rose(rsp_valid_ff), $past(s3_valid_ff && s3_ctrl_ff.emit), "stray result")

endmodule
